### hw/rtl/i2c_ebm_pkg.sv
// Shared types, constants and helper functions of the I2C EEPROM byte master.
// Depends on nothing; every other file of the block uses it by scoped names.
package i2c_ebm_pkg;

   // Width of the segment and write-wait timer, in the range 16 to 32.
   localparam int TIMER_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 24;

   typedef logic [TIMER_WIDTH-1:0] timer_type;

   typedef enum logic [21:0] {
      PH_IDLE = 22'h000001,
      PH_ST0  = 22'h000002,
      PH_ST1  = 22'h000004,
      PH_ST2  = 22'h000008,
      PH_ST3  = 22'h000010,
      PH_TXA  = 22'h000020,
      PH_TXB  = 22'h000040,
      PH_TXC  = 22'h000080,
      PH_TXE  = 22'h000100,
      PH_AKP  = 22'h000200,
      PH_AKH  = 22'h000400,
      PH_AKL  = 22'h000800,
      PH_RD0  = 22'h001000,
      PH_RD1  = 22'h002000,
      PH_RDH  = 22'h004000,
      PH_RDL  = 22'h008000,
      PH_NK0  = 22'h010000,
      PH_NK1  = 22'h020000,
      PH_SP0  = 22'h040000,
      PH_SP1  = 22'h080000,
      PH_SP2  = 22'h100000,
      PH_WW   = 22'h200000
   } phase_type;

   typedef enum logic [3:0] {
      MC_START = 4'd0,
      MC_DEVW  = 4'd1,
      MC_DEVR  = 4'd2,
      MC_MEM   = 4'd3,
      MC_DATA  = 4'd4,
      MC_ACK   = 4'd5,
      MC_READ  = 4'd6,
      MC_NACK  = 4'd7,
      MC_STOP  = 4'd8,
      MC_WAIT  = 4'd9,
      MC_END   = 4'd10
   } macro_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEVICE_ADDRESS = 2'd0,
      CSR_HALF_PERIOD    = 2'd1,
      CSR_ACK_POLL_LIMIT = 2'd2,
      CSR_WRITE_WAIT     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [15:0] half_period_ticks;
      logic [9:0]  ack_poll_limit;
      logic [23:0] write_wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic       req_valid;
      logic       operation;
      logic [7:0] mem_address;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_missing;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] seq;
      logic [3:0] bit_count;
      logic [7:0] shift_byte;
      timer_type  tick_timer;
      logic [9:0] poll_count;
      logic       operation;
      logic [7:0] mem_address;
      logic [7:0] write_data;
      logic [7:0] read_result;
      logic       ack_error;
      logic       scl;
      logic       sda;
      logic       drive;
   } state_type;

   // Transaction plans: the bus step taken at each sequence position.
   function automatic macro_type plan_step(logic operation, logic [3:0] seq);
      macro_type m;
      m = MC_END;
      if (operation) begin
         case (seq)
            4'd0:    m = MC_START;
            4'd1:    m = MC_DEVW;
            4'd2:    m = MC_ACK;
            4'd3:    m = MC_MEM;
            4'd4:    m = MC_ACK;
            4'd5:    m = MC_START;
            4'd6:    m = MC_DEVR;
            4'd7:    m = MC_ACK;
            4'd8:    m = MC_READ;
            4'd9:    m = MC_NACK;
            4'd10:   m = MC_STOP;
            default: m = MC_END;
         endcase
      end else begin
         case (seq)
            4'd0:    m = MC_START;
            4'd1:    m = MC_DEVW;
            4'd2:    m = MC_ACK;
            4'd3:    m = MC_MEM;
            4'd4:    m = MC_ACK;
            4'd5:    m = MC_DATA;
            4'd6:    m = MC_ACK;
            4'd7:    m = MC_STOP;
            4'd8:    m = MC_WAIT;
            default: m = MC_END;
         endcase
      end
      return m;
   endfunction

   // Write-wait length, saturated to the timer width.
   function automatic timer_type clip_wait(logic [23:0] value);
      logic [31:0] wide;
      logic [31:0] limit;
      wide  = 32'(value);
      limit = 32'((64'd1 << TIMER_WIDTH) - 64'd1);
      return timer_type'((wide > limit) ? limit : wide);
   endfunction

endpackage

### hw/rtl/i2c_ebm_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on i2c_ebm_pkg for the payload types.
interface i2c_ebm_req_if;
   logic                 valid;
   logic                 ready;
   i2c_ebm_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface i2c_ebm_rsp_if;
   logic                 valid;
   logic                 ready;
   i2c_ebm_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/i2c_ebm_csr.sv
// Configuration register file of the I2C EEPROM byte master.
// Depends on i2c_ebm_pkg for the register indexes and the config struct.
module i2c_ebm_csr (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        write_enable,
   input  logic [i2c_ebm_pkg::CSR_INDEX_WIDTH-1:0]     index,
   input  logic [i2c_ebm_pkg::CSR_DATA_WIDTH-1:0]      write_data,
   output i2c_ebm_pkg::cfg_type                        cfg
);

   i2c_ebm_pkg::cfg_type cfg_ff;
   i2c_ebm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_enable) begin
         case (i2c_ebm_pkg::csr_index_type'(index))
            i2c_ebm_pkg::CSR_DEVICE_ADDRESS: cfg_in.device_address = write_data[6:0];
            i2c_ebm_pkg::CSR_HALF_PERIOD:    cfg_in.half_period_ticks = write_data[15:0];
            i2c_ebm_pkg::CSR_ACK_POLL_LIMIT: cfg_in.ack_poll_limit = write_data[9:0];
            i2c_ebm_pkg::CSR_WRITE_WAIT:     cfg_in.write_wait_ticks = write_data[23:0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address    <= 7'd80;
         cfg_ff.half_period_ticks <= 16'd11;
         cfg_ff.ack_poll_limit    <= 10'd250;
         cfg_ff.write_wait_ticks  <= 24'd160000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/i2c_ebm_step.sv
// One tick of the bus sequencer: next state and response from state and beat.
// Depends on i2c_ebm_pkg for the phase codes, plans and state struct.
module i2c_ebm_step (
   input  i2c_ebm_pkg::state_type cur_state,
   input  i2c_ebm_pkg::cfg_type   cfg,
   input  i2c_ebm_pkg::req_type   item,
   output i2c_ebm_pkg::state_type next_state,
   output i2c_ebm_pkg::rsp_type   result
);

   i2c_ebm_pkg::state_type work;

   // Enter a pin segment: reload the segment timer and set the pins it names.
   function automatic i2c_ebm_pkg::state_type enter_phase(i2c_ebm_pkg::state_type s,
                                                           i2c_ebm_pkg::phase_type p,
                                                           logic [15:0] half_period);
      i2c_ebm_pkg::state_type r;
      logic [15:0]            h_minus;
      r       = s;
      h_minus = (half_period == 16'd0) ? 16'd0 : half_period - 16'd1;
      r.phase = p;
      r.tick_timer = i2c_ebm_pkg::timer_type'(h_minus);
      case (p)
         i2c_ebm_pkg::PH_ST0: begin r.drive = 1'b1; r.sda = 1'b1; end
         i2c_ebm_pkg::PH_ST1: r.scl = 1'b1;
         i2c_ebm_pkg::PH_ST2: r.sda = 1'b0;
         i2c_ebm_pkg::PH_ST3: r.scl = 1'b0;
         i2c_ebm_pkg::PH_TXA: begin r.scl = 1'b0; r.drive = 1'b1; end
         i2c_ebm_pkg::PH_TXB: r.sda = s.shift_byte[7];
         i2c_ebm_pkg::PH_TXC: r.scl = 1'b1;
         i2c_ebm_pkg::PH_TXE: r.scl = 1'b0;
         i2c_ebm_pkg::PH_AKP: begin
            r.drive      = 1'b0;
            r.scl        = 1'b1;
            r.poll_count = 10'd0;
         end
         i2c_ebm_pkg::PH_AKH: r.phase = p;
         i2c_ebm_pkg::PH_AKL: r.scl = 1'b0;
         i2c_ebm_pkg::PH_RD0: r.drive = 1'b0;
         i2c_ebm_pkg::PH_RD1: r.phase = p;
         i2c_ebm_pkg::PH_RDH: r.scl = 1'b1;
         i2c_ebm_pkg::PH_RDL: r.scl = 1'b0;
         i2c_ebm_pkg::PH_NK0: begin r.drive = 1'b0; r.sda = 1'b1; r.scl = 1'b1; end
         i2c_ebm_pkg::PH_NK1: r.scl = 1'b0;
         i2c_ebm_pkg::PH_SP0: begin r.drive = 1'b1; r.sda = 1'b0; end
         i2c_ebm_pkg::PH_SP1: r.scl = 1'b1;
         i2c_ebm_pkg::PH_SP2: r.sda = 1'b1;
         default:             r.phase = i2c_ebm_pkg::PH_IDLE;
      endcase
      return r;
   endfunction

   // Advance to the next step of the latched transaction's plan.
   function automatic i2c_ebm_pkg::state_type next_macro(i2c_ebm_pkg::state_type s,
                                                          i2c_ebm_pkg::cfg_type c);
      i2c_ebm_pkg::state_type r;
      i2c_ebm_pkg::macro_type m;
      r     = s;
      m     = i2c_ebm_pkg::plan_step(s.operation, s.seq);
      r.seq = s.seq + 4'd1;
      case (m)
         i2c_ebm_pkg::MC_START: r = enter_phase(r, i2c_ebm_pkg::PH_ST0, c.half_period_ticks);
         i2c_ebm_pkg::MC_DEVW: begin
            r.shift_byte = {c.device_address, 1'b0};
            r.bit_count  = 4'd0;
            r = enter_phase(r, i2c_ebm_pkg::PH_TXA, c.half_period_ticks);
         end
         i2c_ebm_pkg::MC_DEVR: begin
            r.shift_byte = {c.device_address, 1'b1};
            r.bit_count  = 4'd0;
            r = enter_phase(r, i2c_ebm_pkg::PH_TXA, c.half_period_ticks);
         end
         i2c_ebm_pkg::MC_MEM: begin
            r.shift_byte = s.mem_address;
            r.bit_count  = 4'd0;
            r = enter_phase(r, i2c_ebm_pkg::PH_TXA, c.half_period_ticks);
         end
         i2c_ebm_pkg::MC_DATA: begin
            r.shift_byte = s.write_data;
            r.bit_count  = 4'd0;
            r = enter_phase(r, i2c_ebm_pkg::PH_TXA, c.half_period_ticks);
         end
         i2c_ebm_pkg::MC_ACK:  r = enter_phase(r, i2c_ebm_pkg::PH_AKP, c.half_period_ticks);
         i2c_ebm_pkg::MC_READ: begin
            r.shift_byte = 8'd0;
            r.bit_count  = 4'd0;
            r = enter_phase(r, i2c_ebm_pkg::PH_RD0, c.half_period_ticks);
         end
         i2c_ebm_pkg::MC_NACK: r = enter_phase(r, i2c_ebm_pkg::PH_NK0, c.half_period_ticks);
         i2c_ebm_pkg::MC_STOP: r = enter_phase(r, i2c_ebm_pkg::PH_SP0, c.half_period_ticks);
         i2c_ebm_pkg::MC_WAIT: begin
            r.phase      = i2c_ebm_pkg::PH_WW;
            r.tick_timer = i2c_ebm_pkg::clip_wait(c.write_wait_ticks);
         end
         default: r.phase = i2c_ebm_pkg::PH_IDLE;
      endcase
      return r;
   endfunction

   always_comb begin
      work = cur_state;
      if (cur_state.phase == i2c_ebm_pkg::PH_IDLE) begin
         if (item.req_valid) begin
            work.operation   = item.operation;
            work.mem_address = item.mem_address;
            work.write_data  = item.write_data;
            work.ack_error   = 1'b0;
            work.seq         = 4'd0;
            work = next_macro(work, cfg);
         end
      end else if (cur_state.phase == i2c_ebm_pkg::PH_AKP) begin
         // The slot ends on a low SDA, or times out once the poll limit is reached.
         if (!item.sda_in) begin
            work = enter_phase(work, i2c_ebm_pkg::PH_AKH, cfg.half_period_ticks);
         end else if (cur_state.poll_count >= cfg.ack_poll_limit) begin
            work.ack_error = 1'b1;
            work = enter_phase(work, i2c_ebm_pkg::PH_AKH, cfg.half_period_ticks);
         end else begin
            work.poll_count = cur_state.poll_count + 10'd1;
         end
      end else if (cur_state.tick_timer != '0) begin
         work.tick_timer = cur_state.tick_timer - i2c_ebm_pkg::timer_type'(1);
      end else begin
         case (cur_state.phase)
            i2c_ebm_pkg::PH_ST0: work = enter_phase(work, i2c_ebm_pkg::PH_ST1,
                                                    cfg.half_period_ticks);
            i2c_ebm_pkg::PH_ST1: work = enter_phase(work, i2c_ebm_pkg::PH_ST2,
                                                    cfg.half_period_ticks);
            i2c_ebm_pkg::PH_ST2: work = enter_phase(work, i2c_ebm_pkg::PH_ST3,
                                                    cfg.half_period_ticks);
            i2c_ebm_pkg::PH_TXA: work = enter_phase(work, i2c_ebm_pkg::PH_TXB,
                                                    cfg.half_period_ticks);
            i2c_ebm_pkg::PH_TXB: work = enter_phase(work, i2c_ebm_pkg::PH_TXC,
                                                    cfg.half_period_ticks);
            i2c_ebm_pkg::PH_TXC: begin
               work.shift_byte = {cur_state.shift_byte[6:0], 1'b0};
               work.bit_count  = cur_state.bit_count + 4'd1;
               if (work.bit_count >= 4'd8) begin
                  work = enter_phase(work, i2c_ebm_pkg::PH_TXE, cfg.half_period_ticks);
               end else begin
                  work = enter_phase(work, i2c_ebm_pkg::PH_TXA, cfg.half_period_ticks);
               end
            end
            i2c_ebm_pkg::PH_AKH: work = enter_phase(work, i2c_ebm_pkg::PH_AKL,
                                                    cfg.half_period_ticks);
            i2c_ebm_pkg::PH_RD0: work = enter_phase(work, i2c_ebm_pkg::PH_RD1,
                                                    cfg.half_period_ticks);
            i2c_ebm_pkg::PH_RD1: work = enter_phase(work, i2c_ebm_pkg::PH_RDH,
                                                    cfg.half_period_ticks);
            i2c_ebm_pkg::PH_RDH: begin
               work.shift_byte = {cur_state.shift_byte[6:0], item.sda_in};
               work.bit_count  = cur_state.bit_count + 4'd1;
               work = enter_phase(work, i2c_ebm_pkg::PH_RDL, cfg.half_period_ticks);
            end
            i2c_ebm_pkg::PH_RDL: begin
               if (cur_state.bit_count >= 4'd8) begin
                  work.read_result = cur_state.shift_byte;
                  work = next_macro(work, cfg);
               end else begin
                  work = enter_phase(work, i2c_ebm_pkg::PH_RDH, cfg.half_period_ticks);
               end
            end
            i2c_ebm_pkg::PH_NK0: work = enter_phase(work, i2c_ebm_pkg::PH_NK1,
                                                    cfg.half_period_ticks);
            i2c_ebm_pkg::PH_SP0: work = enter_phase(work, i2c_ebm_pkg::PH_SP1,
                                                    cfg.half_period_ticks);
            i2c_ebm_pkg::PH_SP1: work = enter_phase(work, i2c_ebm_pkg::PH_SP2,
                                                    cfg.half_period_ticks);
            i2c_ebm_pkg::PH_ST3,
            i2c_ebm_pkg::PH_TXE,
            i2c_ebm_pkg::PH_AKL,
            i2c_ebm_pkg::PH_NK1,
            i2c_ebm_pkg::PH_SP2,
            i2c_ebm_pkg::PH_WW:  work = next_macro(work, cfg);
            default:             work.phase = i2c_ebm_pkg::PH_IDLE;
         endcase
      end
   end

   assign next_state = work;

   always_comb begin
      result.scl_level   = work.scl;
      result.sda_level   = work.sda;
      result.sda_drive   = work.drive;
      result.busy_res    = (work.phase != i2c_ebm_pkg::PH_IDLE);
      // Only the end of a plan brings a running transaction back to idle.
      result.done_res    = (cur_state.phase != i2c_ebm_pkg::PH_IDLE) &&
                           (work.phase == i2c_ebm_pkg::PH_IDLE);
      result.read_data   = work.read_result;
      result.ack_missing = work.ack_error;
   end

endmodule

### hw/rtl/i2c_eeprom_byte_master.sv
// I2C EEPROM byte master, top level: one request beat is one bus tick.
// Each request beat is stepped from the request register into the response register.
// Throughput: one beat per cycle, set by the combinational sequencer step between
// the request register and the response register; back-pressure on rsp stalls it.
// Reset (synchronous, active high) returns the sequencer to idle with SCL, SDA and
// the SDA driver high, and loads the default device address and timings.
module i2c_eeprom_byte_master (
   input  logic                                    clock,
   input  logic                                    reset,
   i2c_ebm_req_if.sink                             req_ch,
   i2c_ebm_rsp_if.source                           rsp_ch,
   input  logic                                    csr_write_enable,
   input  logic [i2c_ebm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [i2c_ebm_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam i2c_ebm_pkg::state_type STATE_RESET = '{
      phase:       i2c_ebm_pkg::PH_IDLE,
      seq:         4'd0,
      bit_count:   4'd0,
      shift_byte:  8'd0,
      tick_timer:  '0,
      poll_count:  10'd0,
      operation:   1'b0,
      mem_address: 8'd0,
      write_data:  8'd0,
      read_result: 8'd0,
      ack_error:   1'b0,
      scl:         1'b1,
      sda:         1'b1,
      drive:       1'b1
   };

   i2c_ebm_pkg::cfg_type   cfg;

   // Request register: holds the beat that the sequencer works on next.
   logic                   in_valid_ff;
   logic                   in_valid_in;
   i2c_ebm_pkg::req_type   in_data_ff;

   // Response register: parts the sequencer from the response channel.
   logic                   out_valid_ff;
   logic                   out_valid_in;
   i2c_ebm_pkg::rsp_type   out_data_ff;

   // Sequencer state, updated once for every beat that moves into the response register.
   i2c_ebm_pkg::state_type state_ff;
   i2c_ebm_pkg::state_type state_in;
   i2c_ebm_pkg::rsp_type   step_rsp;

   logic                   advance;
   logic                   req_take;

   i2c_ebm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .write_data   (csr_write_data),
      .cfg          (cfg)
   );

   i2c_ebm_step u_step (
      .cur_state  (state_ff),
      .cfg        (cfg),
      .item       (in_data_ff),
      .next_state (state_in),
      .result     (step_rsp)
   );

   // The held beat is stepped whenever the response register is free or being emptied.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_ch.payload;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

`ifndef SYNTHESIS
   // A beat that cannot be stepped stays put in the request register.
   a_held_beat_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("request register lost or changed a beat that was not stepped");

   // The sequencer moves only together with a beat entering the response register.
   a_state_moves_with_beat: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("sequencer state changed without a stepped beat");

   // Whenever the sequencer is idle the bus is released high.
   a_idle_bus_high: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == i2c_ebm_pkg::PH_IDLE |-> state_ff.scl && state_ff.sda &&
                                               state_ff.drive)
      else $error("bus pins not at idle levels while sequencer is idle");
`endif

endmodule
